@@ rtl/rbm_pkg.sv @@
// rbm_pkg: shared types and constants for the rgba8 blend modes block
// transaction structs, mode codes and per-lane operand/result records
// no dependencies
package rbm_pkg;

   // cycles from an accepted transaction to its result strobe
   localparam int LATENCY = 12;
   // quotient bits produced by the lane divider
   localparam int QUOT_W  = 9;
   // remainder width inside the divider
   localparam int REM_W   = 27;

   typedef enum logic [3:0] {
      MODE_MIX         = 4'd0,
      MODE_ADD         = 4'd1,
      MODE_SUB         = 4'd2,
      MODE_MUL         = 4'd3,
      MODE_LIGHTEN     = 4'd4,
      MODE_DARKEN      = 4'd5,
      MODE_ERASE_ALPHA = 4'd6,
      MODE_ADD_ALPHA   = 4'd7,
      MODE_INTERP      = 4'd8
   } mode_type;

   // denominator choice of one lane
   typedef enum logic [1:0] {
      DEN_SUM   = 2'd0,
      DEN_255   = 2'd1,
      DEN_65025 = 2'd2
   } den_type;

   // how the merge stage turns a lane quotient into a channel value
   typedef enum logic [2:0] {
      POST_QUOT     = 3'd0,
      POST_PASS     = 3'd1,
      POST_ZERO     = 3'd2,
      POST_SUB_BASE = 3'd3,
      POST_ADD_BASE = 3'd4
   } post_type;

   typedef struct packed {
      logic [7:0] base_red;
      logic [7:0] base_green;
      logic [7:0] base_blue;
      logic [7:0] base_alpha;
      logic [7:0] top_red;
      logic [7:0] top_green;
      logic [7:0] top_blue;
      logic [7:0] top_alpha;
      logic [7:0] mix_factor;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   // lane operands: n = x*c1 +/- y*c2, d chosen by den
   typedef struct packed {
      logic [16:0] x;
      logic [15:0] y;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic        neg;
      den_type     den;
      post_type    post;
      logic [7:0]  base;
   } lane_op_type;

   // lane outcome handed to the merge stage
   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic              clamp;
      post_type          post;
      logic [7:0]        base;
   } lane_res_type;

endpackage

@@ rtl/rgba8_blend_modes_top.sv @@
// rgba8_blend_modes_top: composites a straight-alpha rgba8 top pixel onto a base pixel
// depends on rbm_pkg, rbm_setup, rbm_lane, rbm_merge
//
// Usage:
//   A transaction enters with start high; busy is always low, so one pixel
//   can be taken on every clock. The pixel pair and mix_factor travel in req.
//   After acceptance, rsp_valid is high for one cycle with the blended
//   pixel on rsp. Throughput is one pixel per clock; each result passes
//   through the operand stage, the numerator stage, the nine-stage
//   rounding divider (one quotient bit per stage) in each of the four
//   channel lanes and the merge register.
//   csr_wr_en with csr_wr_data writes the blend mode; change it only while
//   no transaction is in flight. Codes 9 to 15 pass the base through.
//   Synchronous reset clears the mode to mix and drops all in-flight
//   transactions. The receiver cannot stall: each result is shown once.
module rgba8_blend_modes_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rbm_pkg::req_type req,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data,
   output logic             rsp_valid,
   output rbm_pkg::rsp_type rsp
);
   import rbm_pkg::*;

   logic [3:0]         mode_ff;
   logic [3:0]         mode_in;
   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;
   logic               accept;
   lane_op_type        op [4];
   lane_res_type       lane_res [4];
   logic [7:0]         base_c [3];
   logic [7:0]         top_c  [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // mode register
   always_comb begin
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   end

   // valid pipeline
   always_comb begin
      valid_in = {valid_ff[LATENCY-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MIX;
         valid_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   assign base_c = '{req.base_red, req.base_green, req.base_blue};
   assign top_c  = '{req.top_red, req.top_green, req.top_blue};

   // color lanes
   for (genvar i = 0; i < 3; i++) begin : g_color
      rbm_setup u_setup (
         .clock    (clock),
         .cb       (base_c[i]),
         .ct       (top_c[i]),
         .ab       (req.base_alpha),
         .at       (req.top_alpha),
         .factor   (req.mix_factor),
         .mode     (mode_ff),
         .is_alpha (1'b0),
         .op_ff    (op[i])
      );
   end

   // alpha lane
   rbm_setup u_setup_alpha (
      .clock    (clock),
      .cb       (req.base_alpha),
      .ct       (req.top_alpha),
      .ab       (req.base_alpha),
      .at       (req.top_alpha),
      .factor   (req.mix_factor),
      .mode     (mode_ff),
      .is_alpha (1'b1),
      .op_ff    (op[3])
   );

   for (genvar i = 0; i < 4; i++) begin : g_lane
      rbm_lane u_lane (
         .clock (clock),
         .op    (op[i]),
         .res   (lane_res[i])
      );
   end

   rbm_merge u_merge (
      .clock    (clock),
      .lane_res (lane_res),
      .rsp_ff   (rsp)
   );

   assign rsp_valid = valid_ff[LATENCY-1];

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LATENCY) rsp_valid)
      else $error("accepted transaction produced no result");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without matching transaction");

   a_busy_low : assert property (@(posedge clock) disable iff (reset)
      $past(accept) |-> valid_ff[0])
      else $error("accepted transaction missing from pipeline");
`endif

endmodule

@@ rtl/rbm_setup.sv @@
// rbm_setup: per-lane operand selection for one channel, registered
// depends on rbm_pkg
module rbm_setup (
   input  logic                clock,
   input  logic [7:0]          cb,
   input  logic [7:0]          ct,
   input  logic [7:0]          ab,
   input  logic [7:0]          at,
   input  logic [7:0]          factor,
   input  logic [3:0]          mode,
   input  logic                is_alpha,
   output rbm_pkg::lane_op_type op_ff
);
   import rbm_pkg::*;

   lane_op_type op_in;
   logic [7:0]  mt;
   logic [7:0]  mf;
   logic [15:0] mt_ab;
   logic [15:0] t_255;
   logic [15:0] mf_ab;
   logic [15:0] f_at;
   logic [16:0] mul_x;
   logic        w_zero;
   logic [7:0]  c_max;
   logic [7:0]  c_min;

   // shared first-level products
   always_comb begin
      mt     = 8'd255 - at;
      mf     = 8'd255 - factor;
      mt_ab  = {8'd0, mt} * {8'd0, ab};
      t_255  = {8'd0, at} * 16'd255;
      mf_ab  = {8'd0, mf} * {8'd0, ab};
      f_at   = {8'd0, factor} * {8'd0, at};
      // multiply weight: 255*mt + t*ct, at most 255*255
      mul_x  = 17'(mt) * 17'd255 + 17'(at) * 17'(ct);
      w_zero = ((mf == 8'd0) || (ab == 8'd0)) && ((factor == 8'd0) || (at == 8'd0));
      c_max  = (cb > ct) ? cb : ct;
      c_min  = (cb < ct) ? cb : ct;
   end

   // operand decode per mode
   always_comb begin
      op_in      = '0;
      op_in.den  = DEN_255;
      op_in.post = POST_PASS;
      op_in.base = is_alpha ? ab : cb;
      if (mode == MODE_INTERP) begin
         op_in.x = 17'(mf_ab);
         op_in.y = f_at;
         if (is_alpha) begin
            op_in.c1   = 8'd1;
            op_in.c2   = 8'd1;
            op_in.post = w_zero ? POST_ZERO : POST_QUOT;
         end else begin
            op_in.c1   = cb;
            op_in.c2   = ct;
            op_in.den  = DEN_SUM;
            op_in.post = w_zero ? POST_PASS : POST_QUOT;
         end
      end else if (at != 8'd0) begin
         unique case (mode)
            MODE_MIX: begin
               op_in.x = 17'(mt_ab);
               op_in.y = t_255;
               op_in.post = POST_QUOT;
               if (is_alpha) begin
                  op_in.c1 = 8'd1;
                  op_in.c2 = 8'd1;
               end else begin
                  op_in.c1  = cb;
                  op_in.c2  = ct;
                  op_in.den = DEN_SUM;
               end
            end
            MODE_ADD, MODE_SUB: begin
               if (!is_alpha) begin
                  op_in.x    = 17'd255;
                  op_in.y    = {8'd0, at};
                  op_in.c1   = cb;
                  op_in.c2   = ct;
                  op_in.neg  = (mode == MODE_SUB);
                  op_in.post = POST_QUOT;
               end
            end
            MODE_MUL: begin
               if (!is_alpha) begin
                  op_in.x    = mul_x;
                  op_in.c1   = cb;
                  op_in.den  = DEN_65025;
                  op_in.post = POST_QUOT;
               end
            end
            MODE_LIGHTEN, MODE_DARKEN: begin
               if (!is_alpha) begin
                  op_in.x    = {9'd0, mt};
                  op_in.y    = {8'd0, at};
                  op_in.c1   = cb;
                  op_in.c2   = (mode == MODE_LIGHTEN) ? c_max : c_min;
                  op_in.post = POST_QUOT;
               end
            end
            MODE_ERASE_ALPHA, MODE_ADD_ALPHA: begin
               if (is_alpha) begin
                  op_in.x    = {9'd0, at};
                  op_in.c1   = at;
                  op_in.post = (mode == MODE_ERASE_ALPHA) ? POST_SUB_BASE : POST_ADD_BASE;
               end
            end
            default: begin
               op_in.post = POST_PASS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

@@ rtl/rbm_lane.sv @@
// rbm_lane: numerator/denominator stage and pipelined rounding divider
// depends on rbm_pkg
module rbm_lane (
   input  logic                  clock,
   input  rbm_pkg::lane_op_type  op,
   output rbm_pkg::lane_res_type res
);
   import rbm_pkg::*;

   typedef struct packed {
      logic     clamp;
      post_type post;
      logic [7:0] base;
   } meta_type;

   logic [24:0]       prod1;
   logic [24:0]       prod2;
   logic [25:0]       n_val;
   logic [16:0]       d_val;
   logic              clamp_in;

   logic [REM_W-1:0]  rem_ff  [0:QUOT_W];
   logic [17:0]       den_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] quot_ff [0:QUOT_W];
   meta_type          meta_ff [0:QUOT_W];

   // numerator and denominator
   always_comb begin
      prod1    = 25'(op.x) * 25'(op.c1);
      prod2    = 25'(op.y) * 25'(op.c2);
      clamp_in = op.neg && (prod1 < prod2);
      if (op.neg) begin
         n_val = clamp_in ? 26'd0 : 26'(prod1 - prod2);
      end else begin
         n_val = 26'(prod1) + 26'(prod2);
      end
      case (op.den)
         DEN_SUM:   d_val = op.x + 17'(op.y);
         DEN_65025: d_val = 17'd65025;
         default:   d_val = 17'd255;
      endcase
   end

   // rounding: floor((2n + d) / 2d)
   always_ff @(posedge clock) begin
      rem_ff[0]  <= REM_W'({n_val, 1'b0}) + REM_W'(d_val);
      den_ff[0]  <= {d_val, 1'b0};
      quot_ff[0] <= '0;
      meta_ff[0] <= '{clamp: clamp_in, post: op.post, base: op.base};
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < QUOT_W; s++) begin : g_div
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;

      always_comb begin
         trial   = REM_W'(den_ff[s]) << (QUOT_W - 1 - s);
         rem_in  = rem_ff[s];
         quot_in = quot_ff[s];
         if (rem_ff[s] >= trial) begin
            rem_in = rem_ff[s] - trial;
            quot_in[QUOT_W-1-s] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= rem_in;
         den_ff[s+1]  <= den_ff[s];
         quot_ff[s+1] <= quot_in;
         meta_ff[s+1] <= meta_ff[s];
      end
   end

   assign res = '{quot: quot_ff[QUOT_W], clamp: meta_ff[QUOT_W].clamp,
                  post: meta_ff[QUOT_W].post, base: meta_ff[QUOT_W].base};

endmodule

@@ rtl/rbm_merge.sv @@
// rbm_merge: saturation, clamping and packing of the four lane results
// depends on rbm_pkg
module rbm_merge (
   input  logic                  clock,
   input  rbm_pkg::lane_res_type lane_res [4],
   output rbm_pkg::rsp_type      rsp_ff
);
   import rbm_pkg::*;

   logic [7:0] chan [4];
   rsp_type    rsp_in;

   // final value of each channel
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         case (lane_res[i].post)
            POST_QUOT: begin
               if (lane_res[i].clamp) begin
                  chan[i] = 8'd0;
               end else if (lane_res[i].quot[QUOT_W-1]) begin
                  chan[i] = 8'd255;
               end else begin
                  chan[i] = lane_res[i].quot[7:0];
               end
            end
            POST_ZERO: chan[i] = 8'd0;
            POST_SUB_BASE: begin
               chan[i] = (9'(lane_res[i].base) > lane_res[i].quot)
                         ? 8'(9'(lane_res[i].base) - lane_res[i].quot) : 8'd0;
            end
            POST_ADD_BASE: begin
               chan[i] = ((10'(lane_res[i].base) + 10'(lane_res[i].quot)) > 10'd255)
                         ? 8'd255 : 8'(lane_res[i].base + lane_res[i].quot[7:0]);
            end
            default: chan[i] = lane_res[i].base;
         endcase
      end
      rsp_in = '{out_red: chan[0], out_green: chan[1], out_blue: chan[2],
                 out_alpha: chan[3]};
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
